### design/bffa_pkg.sv
// shared constants and types for the bitmap first-fit block allocator
// no dependencies; compile first
package bffa_pkg;

  localparam int WORD_W         = 32;
  localparam int BIT_W          = $clog2(WORD_W);
  localparam int INDEX_W        = 12;
  localparam int BC_W           = 13;
  localparam int TOTAL_W        = 13;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;
  localparam int REG_SEL_BIT    = 2;
  localparam int DEF_MAX_BLOCKS = 4096;

  localparam logic [BC_W-1:0] BC_RESET = BC_W'(4096);

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_UNAVAIL = 3'd1,
    ST_FULL    = 3'd2,
    ST_RANGE   = 3'd3,
    ST_FREE    = 3'd4
  } status_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_ENABLED     = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } reg_index_t;

endpackage

### design/bffa_req_if.sv
// request channel of the allocator: valid/ready plus opcode and release index
// depends on bffa_pkg
interface bffa_req_if;
  import bffa_pkg::*;

  logic                 valid;
  logic                 ready;
  opcode_t              opcode;
  logic [INDEX_W-1:0]   release_index;

  modport source (output valid, output opcode, output release_index, input ready);
  modport sink   (input valid, input opcode, input release_index, output ready);

endinterface

### design/bffa_rsp_if.sv
// response channel of the allocator: valid/ready plus status, index and total
// depends on bffa_pkg
interface bffa_rsp_if;
  import bffa_pkg::*;

  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [INDEX_W-1:0]   granted_index;
  logic [TOTAL_W-1:0]   used_total;

  modport source (output valid, output status, output granted_index, output used_total,
                  input ready);
  modport sink   (input valid, input status, input granted_index, input used_total,
                  output ready);

endinterface

### design/bitmap_first_fit_block_allocator_unit.sv
// accept to rsp.valid: disabled, out of range or no blocks go straight to finish; a release
// passes read, modify, finish; an allocate scans groups of 1024 blocks (1..NG), then read,
// modify, finish, or finish if none is free; one request at a time for the one-port
// read/modify/write: the next transfer is taken once the result is registered
// reset: counter zero, enabled 1, block_count 4096; per-word valid bits make the whole bitmap
// read as free at once, no clearing pass
module bitmap_first_fit_block_allocator_unit #(
  parameter int MAX_BLOCKS = bffa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                       clk,
  input  logic                       rst,
  bffa_req_if.sink                   req,
  bffa_rsp_if.source                 rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bffa_pkg::ADDR_W-1:0] paddr,
  input  logic [bffa_pkg::DATA_W-1:0] pwdata,
  output logic [bffa_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import bffa_pkg::*;

  // block_count cannot name more than 2**BC_W - 1 blocks, so storage is capped at 2**BC_W
  localparam int CAP  = (MAX_BLOCKS < (2 ** BC_W)) ? MAX_BLOCKS : (2 ** BC_W);
  localparam int NW   = (CAP + WORD_W - 1) / WORD_W;
  localparam int WA_W = (NW > 1) ? $clog2(NW) : 1;
  localparam int NG   = (NW + WORD_W - 1) / WORD_W;
  localparam int GA_W = (NG > 1) ? $clog2(NG) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_READ   = 5'b00100,
    S_MODIFY = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } zero_hit_t;

  // lowest clear bit of a word
  function automatic zero_hit_t first_zero(input logic [WORD_W-1:0] v);
    zero_hit_t r;
    r.found = 1'b0;
    r.pos   = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (!v[j]) begin
        r.found = 1'b1;
        r.pos   = BIT_W'(j);
      end
    end
    return r;
  endfunction

  // configuration registers
  logic            enabled;
  logic [BC_W-1:0] block_count;

  // control and bookkeeping
  state_t            state;
  logic [GA_W-1:0]   group;
  logic [WA_W-1:0]   word_addr;
  opcode_t           op_q;
  logic [INDEX_W-1:0] idx_q;
  logic [BC_W-1:0]   used_counter;
  logic [NW-1:0]     word_valid;   // word was written since reset
  logic [NW-1:0]     word_full;    // all 32 used bits of the word set

  // bitmap memory, one word of used bits per entry, registered read
  logic [WORD_W-1:0] mem [NW];
  logic [WORD_W-1:0] rd_data;
  logic              rd_valid;

  // result staging and output register
  status_t            res_status;
  logic [INDEX_W-1:0] res_granted;
  logic               out_valid;
  status_t            out_status;
  logic [INDEX_W-1:0] out_granted;
  logic [TOTAL_W-1:0] out_total;

  // combinational helpers
  logic [BC_W-1:0]         limit;
  logic [BC_W-1:0]         limit_m1;
  logic [BC_W-1:0]         last_word;
  logic [NG*WORD_W-1:0]    full_pad;
  logic [WORD_W-1:0]       grp_bits;
  zero_hit_t               grp_hit;
  logic [BC_W-1:0]         scan_word;
  logic [WORD_W-1:0]       cur_word;
  zero_hit_t               word_hit;
  logic [BC_W-1:0]         alloc_idx;
  logic                    alloc_ok;
  logic                    rel_used;
  logic                    mem_we;
  logic [WORD_W-1:0]       mem_wdata;
  logic                    req_xfer;
  logic                    cfg_we;

  // ---------------------------------------------------------------------------
  // configuration port: pready is tied high, registers decoded by paddr bit 2
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled     <= 1'b1;
      block_count <= BC_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(paddr[REG_SEL_BIT]))
        REG_ENABLED:     enabled     <= pwdata[0];
        REG_BLOCK_COUNT: block_count <= pwdata[BC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[REG_SEL_BIT]))
      REG_ENABLED:     prdata = {{(DATA_W-1){1'b0}}, enabled};
      REG_BLOCK_COUNT: prdata = {{(DATA_W-BC_W){1'b0}}, block_count};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // active range: block_count clamped to the built capacity
  // ---------------------------------------------------------------------------
  always_comb begin
    if ({1'b0, block_count} > (BC_W + 1)'(CAP)) begin
      limit = BC_W'(CAP);
    end else begin
      limit = block_count;
    end
    limit_m1  = limit - BC_W'(1);
    last_word = BC_W'(limit_m1 >> BIT_W);
  end

  // ---------------------------------------------------------------------------
  // group scan: 32 word-full flags per cycle, words past the memory count as full
  // ---------------------------------------------------------------------------
  always_comb begin
    full_pad           = '1;
    full_pad[NW-1:0]   = word_full;
  end

  assign grp_bits  = full_pad[group*WORD_W +: WORD_W];
  assign grp_hit   = first_zero(grp_bits);
  assign scan_word = BC_W'({group, grp_hit.pos});

  // ---------------------------------------------------------------------------
  // modify stage: a never-written word reads as all free
  // ---------------------------------------------------------------------------
  assign cur_word  = rd_valid ? rd_data : '0;
  assign word_hit  = first_zero(cur_word);
  assign alloc_idx = BC_W'({word_addr, word_hit.pos});
  assign alloc_ok  = word_hit.found && (alloc_idx < limit);
  assign rel_used  = cur_word[idx_q[BIT_W-1:0]];

  always_comb begin
    if (op_q == OP_ALLOC) begin
      mem_we    = (state == S_MODIFY) && alloc_ok;
      mem_wdata = cur_word | (WORD_W'(1) << word_hit.pos);
    end else begin
      mem_we    = (state == S_MODIFY) && rel_used;
      mem_wdata = cur_word & ~(WORD_W'(1) << idx_q[BIT_W-1:0]);
    end
  end

  // read happens only in S_READ and the write only in S_MODIFY of the same request,
  // so the fsm keeps read and write of one entry from ever overlapping
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[word_addr] <= mem_wdata;
    end
    if (state == S_READ) begin
      rd_data  <= mem[word_addr];
      rd_valid <= word_valid[word_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // request sequencer
  // ---------------------------------------------------------------------------
  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid & req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      group        <= '0;
      used_counter <= '0;
      word_valid   <= '0;
      word_full    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            group <= '0;
            if (!enabled) begin
              state <= S_FINISH;
            end else if (req.opcode == OP_ALLOC) begin
              state <= (limit == '0) ? S_FINISH : S_SCAN;
            end else if (BC_W'(req.release_index) >= limit) begin
              state <= S_FINISH;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_SCAN: begin
          // first non-full word past the active range means no free block
          if (grp_hit.found) begin
            state <= (scan_word > last_word) ? S_FINISH : S_READ;
          end else if (group == GA_W'(NG - 1)) begin
            state <= S_FINISH;
          end else begin
            group <= group + GA_W'(1);
          end
        end
        S_READ: begin
          state <= S_MODIFY;
        end
        S_MODIFY: begin
          if (mem_we) begin
            word_valid[word_addr] <= 1'b1;
            word_full[word_addr]  <= &mem_wdata;
            if (op_q == OP_ALLOC) begin
              used_counter <= used_counter + BC_W'(1);
            end else if (used_counter != '0) begin
              used_counter <= used_counter - BC_W'(1);
            end
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          // hold here while an older result still waits on the output
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload of the request and the result being built
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_xfer) begin
          op_q        <= req.opcode;
          idx_q       <= req.release_index;
          word_addr   <= WA_W'(req.release_index >> BIT_W);
          res_granted <= '0;
          if (!enabled) begin
            res_status <= ST_UNAVAIL;
          end else if (req.opcode == OP_ALLOC) begin
            res_status <= ST_FULL;
          end else if (BC_W'(req.release_index) >= limit) begin
            res_status <= ST_RANGE;
          end else begin
            res_status <= ST_DONE;
          end
        end
      end
      S_SCAN: begin
        if (grp_hit.found) begin
          word_addr <= WA_W'(scan_word);
        end
      end
      S_MODIFY: begin
        if (op_q == OP_ALLOC) begin
          if (alloc_ok) begin
            res_status  <= ST_DONE;
            res_granted <= INDEX_W'(alloc_idx);
          end else begin
            res_status  <= ST_FULL;
          end
        end else begin
          res_status <= rel_used ? ST_DONE : ST_FREE;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // output register: decouples the sequencer from a stalled consumer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FINISH) && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && (!out_valid || rsp.ready)) begin
      out_status  <= res_status;
      out_granted <= res_granted;
      out_total   <= TOTAL_W'(used_counter);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.granted_index = out_granted;
  assign rsp.used_total    = out_total;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // word summary flags follow every write of the bitmap
  a_full_tracks_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (word_valid[$past(word_addr)] &&
                (word_full[$past(word_addr)] == (&$past(mem_wdata)))))
    else $error("word summary flags do not match written bitmap word");

  // the used count moves only in the modify step
  a_counter_only_modify: assert property (@(posedge clk) disable iff (rst)
    (state != S_MODIFY) |=> $stable(used_counter))
    else $error("used counter changed outside the modify step");

  // only a successful request carries a nonzero granted index
  a_grant_zero_unless_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_DONE)) |-> (out_granted == '0))
    else $error("granted index nonzero on a failed request");

  // an allocate result that is done always names a block inside the active range
  a_grant_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MODIFY && op_q == OP_ALLOC && mem_we) |-> (alloc_idx < limit))
    else $error("allocation granted a block past the active range");

endmodule

### dv/bffa_alloc_checker.sv
// allocator checker: watches the request, response and register ports,
// predicts each response from its own copy of the bitmap and compares
// depends on bffa_pkg, bffa_req_if and bffa_rsp_if
module bffa_alloc_checker #(
  parameter int MAX_BLOCKS = bffa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                        clk,
  input  logic                        rst,
  bffa_req_if                         req,
  bffa_rsp_if                         rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bffa_pkg::ADDR_W-1:0] paddr,
  input  logic [bffa_pkg::DATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          mismatches,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import bffa_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] granted_index;
    logic [TOTAL_W-1:0] used_total;
  } outcome_t;

  logic            block_used [MAX_BLOCKS];
  int unsigned     used_tally;
  logic            store_enabled;
  logic [BC_W-1:0] block_limit;
  outcome_t        pending_outcomes [$];
  outcome_t        oldest;
  int              fail_cnt;

  // first-fit search and release on the local bitmap copy
  function automatic outcome_t resolve_request(opcode_t op, logic [INDEX_W-1:0] idx);
    outcome_t    o;
    int unsigned span;
    span = (block_limit > MAX_BLOCKS) ? MAX_BLOCKS : block_limit;
    o.granted_index = '0;
    if (!store_enabled) begin
      o.status = ST_UNAVAIL;
    end else if (op == OP_ALLOC) begin
      o.status = ST_FULL;
      for (int k = 0; k < span; k++) begin
        if (!block_used[k]) begin
          block_used[k]   = 1'b1;
          used_tally++;
          o.granted_index = INDEX_W'(k);
          o.status        = ST_DONE;
          break;
        end
      end
    end else if (idx >= span) begin
      o.status = ST_RANGE;
    end else if (!block_used[idx]) begin
      o.status = ST_FREE;
    end else begin
      block_used[idx] = 1'b0;
      if (used_tally != 0) used_tally--;
      o.status = ST_DONE;
    end
    o.used_total = TOTAL_W'(used_tally);
    return o;
  endfunction

  task automatic note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  initial begin
    fail_cnt      = 0;
    used_tally    = 0;
    store_enabled = 1'b1;
    block_limit   = BC_RESET;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_BLOCKS; k++) block_used[k] = 1'b0;
      used_tally    = 0;
      store_enabled = 1'b1;
      block_limit   = BC_RESET;
      pending_outcomes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[REG_SEL_BIT]))
          REG_ENABLED:     store_enabled = pwdata[0];
          REG_BLOCK_COUNT: block_limit   = pwdata[BC_W-1:0];
          default: ;
        endcase
      end
      // responses first so a stray one never pairs with a request of this edge
      if (rsp.valid && rsp.ready) begin
        if (pending_outcomes.size() == 0) begin
          note_failure($sformatf("response with nothing pending: status %0d index %0d total %0d",
                                 rsp.status, rsp.granted_index, rsp.used_total));
        end else begin
          oldest = pending_outcomes.pop_front();
          if (rsp.status !== oldest.status || rsp.granted_index !== oldest.granted_index ||
              rsp.used_total !== oldest.used_total) begin
            note_failure($sformatf({"mismatch: status exp %0d got %0d, index exp %0d got %0d,",
                                    " total exp %0d got %0d"},
                                   oldest.status, rsp.status, oldest.granted_index,
                                   rsp.granted_index, oldest.used_total, rsp.used_total));
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_outcomes.push_back(resolve_request(req.opcode, req.release_index));
      end
    end
    outstanding <= pending_outcomes.size();
    mismatches  <= fail_cnt;
  end

endmodule

### dv/bitmap_first_fit_block_allocator_unit_tb.sv
// testbench top for the bitmap first-fit block allocator: clock, reset,
// request and register stimulus, response back-pressure and the verdict
// depends on bffa_pkg, both channel interfaces, the allocator and bffa_alloc_checker
module bitmap_first_fit_block_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bffa_pkg::*;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                mismatches;
  int                outstanding;

  // stimulus shaping shared with the response side
  bit                gaps_on = 1'b1;
  logic              steady  = 1'b0;
  logic              hold_req = 1'b0;

  bffa_req_if req_ch ();
  bffa_rsp_if rsp_ch ();

  bitmap_first_fit_block_allocator_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bffa_alloc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  // one request transfer, with random idle cycles in front of it;
  // returns in the time step of the accepting edge
  task automatic push_request(opcode_t op, logic [INDEX_W-1:0] idx);
    while (gaps_on && $urandom_range(0, 99) < 8) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.release_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // register write: setup cycle, then access cycle until pready, then idle again
  task automatic write_reg(reg_index_t r, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(r) << REG_SEL_BIT);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait for every pending response, plus a margin
  // over the longest allocate latency
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // response side: mostly ready, one long hold-off on request, and a
  // stretch with no back-pressure while steady is set
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held       = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held       = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  initial begin
    int              r;
    int              span;
    logic [BC_W-1:0] bc;
    logic            en_bit;

    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.opcode        <= OP_ALLOC;
    req_ch.release_index <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, full capacity
    push_request(OP_ALLOC, '0);                 // grants 0
    push_request(OP_ALLOC, '1);                 // grants 1, index field ignored
    push_request(OP_ALLOC, '0);                 // grants 2
    push_request(OP_RELEASE, INDEX_W'(1));      // done
    push_request(OP_RELEASE, INDEX_W'(1));      // already free
    push_request(OP_RELEASE, '1);               // top block, in range but free
    push_request(OP_ALLOC, '0);                 // hole at 1 refilled first
    push_request(OP_ALLOC, '0);                 // grants 3

    // four blocks, all used: full, and release at the count is out of range
    settle();
    write_reg(REG_BLOCK_COUNT, DATA_W'(4));
    push_request(OP_ALLOC, '0);
    push_request(OP_RELEASE, INDEX_W'(4));

    // count shrunk below used blocks: block 3 stays used but unreachable
    settle();
    write_reg(REG_BLOCK_COUNT, DATA_W'(2));
    push_request(OP_RELEASE, INDEX_W'(3));
    push_request(OP_ALLOC, '0);
    push_request(OP_RELEASE, INDEX_W'(1));
    push_request(OP_ALLOC, '0);

    // zero blocks: allocate is full, every release out of range
    settle();
    write_reg(REG_BLOCK_COUNT, DATA_W'(0));
    push_request(OP_ALLOC, '0);
    push_request(OP_RELEASE, '0);

    // disabled: everything unavailable, total unchanged
    settle();
    write_reg(REG_ENABLED, DATA_W'(0));
    push_request(OP_ALLOC, '0);
    push_request(OP_RELEASE, INDEX_W'(2));

    // count above capacity clamps to the built size
    settle();
    write_reg(REG_ENABLED, DATA_W'(1));
    write_reg(REG_BLOCK_COUNT, DATA_W'(13'h1FFF));
    push_request(OP_RELEASE, '1);
    push_request(OP_ALLOC, '0);                 // grants 4
    push_request(OP_RELEASE, INDEX_W'(2048));

    // random phases, mostly small block counts so full and refill happen often
    for (int ph = 0; ph < 10; ph++) begin
      settle();
      r = $urandom_range(0, 99);
      if (ph == 0)     bc = BC_W'(1);
      else if (r < 70) bc = BC_W'($urandom_range(1, 40));
      else if (r < 80) bc = BC_W'($urandom_range(41, 300));
      else if (r < 88) bc = BC_W'($urandom_range(0, 1));
      else if (r < 94) bc = BC_W'(DEF_MAX_BLOCKS);
      else             bc = BC_W'($urandom_range(DEF_MAX_BLOCKS + 1, 8191));
      en_bit = ($urandom_range(0, 99) >= 12);
      write_reg(REG_ENABLED, DATA_W'(en_bit));
      write_reg(REG_BLOCK_COUNT, DATA_W'(bc));
      span = (bc > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : int'(bc);

      // one phase runs back to back on both sides
      gaps_on = (ph != 3);
      steady <= (ph == 3);

      for (int n = 0; n < 40; n++) begin
        // long response hold-off while requests keep coming
        if (ph == 5 && n == 10) hold_req <= 1'b1;
        // sender pause mid-phase until everything has drained
        if (ph == 7 && n == 20) settle();
        r = $urandom_range(0, 99);
        if (r < 50) begin
          push_request(OP_ALLOC, INDEX_W'($urandom));
        end else if (r < 85 && span != 0) begin
          push_request(OP_RELEASE, INDEX_W'($urandom_range(0, span - 1)));
        end else begin
          push_request(OP_RELEASE, INDEX_W'($urandom));
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### bitmap_first_fit_block_allocator_unit.f
design/bffa_pkg.sv
design/bffa_req_if.sv
design/bffa_rsp_if.sv
design/bitmap_first_fit_block_allocator_unit.sv
dv/bffa_alloc_checker.sv
dv/bitmap_first_fit_block_allocator_unit_tb.sv
